// File: rtl/dkt_pkg.sv
`timescale 1ns / 1ps

package dkt_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_AXES      = 3;
    localparam int AXIS_W        = 2;
    localparam int DEF_AXES      = 3;
    localparam int DEF_FRAC_BITS = 16;
    localparam int VAR_INIT_SCALE = 100;

    // operation codes of an input item
    localparam logic [1:0] FN_INIT    = 2'd0;
    localparam logic [1:0] FN_PREDICT = 2'd1;
    localparam logic [1:0] FN_UPDATE  = 2'd2;
    localparam logic [1:0] FN_RSVD    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PROC_NOISE = 2'd0;
    localparam logic [1:0] CFG_MEAS_NOISE = 2'd1;
    localparam logic [1:0] CFG_INIT_PVAR  = 2'd2;
    localparam logic [1:0] CFG_INIT_VVAR  = 2'd3;

endpackage

// File: rtl/dkt_mul.sv
`timescale 1ns / 1ps

module dkt_mul (
    input  logic                            i_clk,
    input  logic [dkt_pkg::DATA_W-1:0]      i_a,
    input  logic [dkt_pkg::DATA_W-1:0]      i_b,
    output logic [2*dkt_pkg::DATA_W-1:0]    o_p
);

    logic [2*dkt_pkg::DATA_W-1:0] r_p;

    // register the product of the shared multiplier
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: rtl/dkt_div.sv
`timescale 1ns / 1ps

module dkt_div #(
    parameter int DVD_W = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DVD_W-1:0]              i_dividend,
    input  logic [dkt_pkg::DATA_W:0]      i_divisor,
    output logic                          o_done,
    output logic [DVD_W-1:0]              o_quot
);

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int REM_W = dkt_pkg::DATA_W + 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] r_dsr;
    logic [DVD_W-1:0] r_quo;
    logic [REM_W:0]   n_trial;
    logic             n_fit;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        n_trial = {r_rem, r_quo[DVD_W-1]};
        n_fit   = (n_trial >= {1'b0, r_dsr});
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= n_fit ? REM_W'(n_trial - {1'b0, r_dsr}) : REM_W'(n_trial);
                r_quo <= {r_quo[DVD_W-2:0], n_fit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: rtl/diagonal_kalman_tracker_3d_core.sv
`timescale 1ns / 1ps
// Channel   | valid    | stall    | payload
// input     | i_valid  | o_stall  | i_func, i_coord_x/y/z, i_time_stamp
// result    | o_valid  | i_stall  | o_pos_x/y/z, o_vel_x/y/z, o_step_skipped
// config    | i_cfg_we | (none)   | i_cfg_idx, i_cfg_data
//
// Init, an unknown operation and a skipped predict go straight to the done state.
// Predict runs on the one shared 32x32 multiplier.
// Update runs the bit-serial divider (two divisions per axis), then
// the shared multiplier, axis by axis.
// Reset is synchronous; it loads the register defaults and clears the track.
// A waiting result sits in an output register; a new item is taken meanwhile.

module diagonal_kalman_tracker_3d_core #(
    parameter int AXES      = dkt_pkg::DEF_AXES,
    parameter int FRAC_BITS = dkt_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic [31:0]        i_time_stamp,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z,
    output logic               o_step_skipped,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    localparam int DW     = dkt_pkg::DATA_W;
    localparam int NA     = dkt_pkg::MAX_AXES;
    localparam int AW     = dkt_pkg::AXIS_W;
    localparam int DVD_W  = DW + FRAC_BITS;
    localparam int PROD_W = 2 * DW;
    localparam int CORR_W = PROD_W - FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [DW-1:0] ONE_FX   = DW'(64'd1 << FRAC_BITS);
    localparam logic [DW-1:0] VVAR_RST = DW'(64'(dkt_pkg::VAR_INIT_SCALE) << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] S32_MIN = SUM_W'(-64'sd2147483648);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_APPLY = 3'd2;
    localparam logic [2:0] ST_AXIS  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // multiplier operations
    localparam logic [2:0] OP_GROW  = 3'd0;
    localparam logic [2:0] OP_PPOS  = 3'd1;
    localparam logic [2:0] OP_KPOS  = 3'd2;
    localparam logic [2:0] OP_KVVEL = 3'd3;
    localparam logic [2:0] OP_PPVAR = 3'd4;
    localparam logic [2:0] OP_PVVAR = 3'd5;

    logic [2:0]           r_state;
    logic [2:0]           r_op;
    logic [AW-1:0]        r_axis;
    logic [DW-1:0]        r_pn, r_mn, r_ipv, r_ivv;
    logic signed [DW-1:0] r_pos [NA];
    logic signed [DW-1:0] r_vel [NA];
    logic [DW-1:0]        r_pvar [NA];
    logic [DW-1:0]        r_vvar [NA];
    logic signed [DW-1:0] r_coord [NA];
    logic [DW-1:0]        r_last, r_ts, r_dt;
    logic [CORR_W-1:0]    r_grow;
    logic                 r_skip;
    logic [DW-1:0]        r_k, r_kv, r_imag;
    logic                 r_ineg, r_szero, r_div_kv;
    logic                 r_ovalid;
    logic signed [DW-1:0] r_opos [NA];
    logic signed [DW-1:0] r_ovel [NA];
    logic                 r_oskip;
    logic                 r_div_start;

    logic signed [DW-1:0] in_coord [NA];
    logic [DW-1:0]        n_dt;
    logic [DW-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [CORR_W-1:0]    corr;
    logic [DW:0]          div_dsr;
    logic [DVD_W-1:0]     div_dvd, div_q;
    logic                 div_done;
    logic signed [DW:0]   n_innov;
    logic                 last_axis;
    logic [DW-1:0]        vel_mag;

    assign in_coord[0] = i_coord_x;
    assign in_coord[1] = i_coord_y;
    assign in_coord[2] = i_coord_z;

    // base + sign * corr, clamped to signed 32 bits
    function automatic logic signed [DW-1:0] add_scaled(
        input logic signed [DW-1:0] base,
        input logic [CORR_W-1:0]    c,
        input logic                 neg
    );
        logic signed [SUM_W-1:0] b, m, s;
        b = SUM_W'(base);
        m = signed'(SUM_W'(c));
        s = neg ? b - m : b + m;
        if (s > S32_MAX)      add_scaled = S32_MAX[DW-1:0];
        else if (s < S32_MIN) add_scaled = S32_MIN[DW-1:0];
        else                  add_scaled = s[DW-1:0];
    endfunction

    // variance + growth, clamped to unsigned 32 bits
    function automatic logic [DW-1:0] add_sat(
        input logic [DW-1:0]     v,
        input logic [CORR_W-1:0] g
    );
        logic [CORR_W:0] s;
        s = (CORR_W + 1)'(v) + (CORR_W + 1)'(g);
        add_sat = (|s[CORR_W:DW]) ? '1 : s[DW-1:0];
    endfunction

    assign n_dt      = i_time_stamp - r_last;
    assign corr      = mul_p[PROD_W-1:FRAC_BITS];
    assign last_axis = (r_axis == AW'(AXES - 1));
    assign vel_mag   = r_vel[r_axis][DW-1] ? DW'(-r_vel[r_axis]) : r_vel[r_axis];
    assign n_innov   = (DW + 1)'(r_coord[r_axis]) - (DW + 1)'(r_pos[r_axis]);

    // pick the multiplier operands for the current operation
    always_comb begin
        case (r_op)
            OP_GROW:  begin mul_a = r_pn;  mul_b = r_dt;              end
            OP_PPOS:  begin mul_a = r_dt;  mul_b = vel_mag;           end
            OP_KPOS:  begin mul_a = r_k;   mul_b = r_imag;            end
            OP_KVVEL: begin mul_a = r_kv;  mul_b = r_imag;            end
            OP_PPVAR: begin mul_a = r_pvar[r_axis]; mul_b = ONE_FX - r_k; end
            OP_PVVAR: begin mul_a = r_vvar[r_axis]; mul_b = ONE_FX - r_k; end
            default:  begin mul_a = '0;    mul_b = '0;                end
        endcase
    end

    // divider operands: gain numerator over innovation covariance
    assign div_dsr = (DW + 1)'(r_pvar[r_axis]) + (DW + 1)'(r_mn);
    assign div_dvd = {r_div_kv ? r_vvar[r_axis] : r_pvar[r_axis], FRAC_BITS'(0)};

    dkt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    dkt_div #(.DVD_W(DVD_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // sequencer and track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_op          <= OP_GROW;
            r_axis        <= '0;
            r_ovalid      <= 1'b0;
            r_div_start   <= 1'b0;
            r_skip        <= 1'b0;
            r_pn          <= ONE_FX;
            r_mn          <= ONE_FX;
            r_ipv         <= ONE_FX;
            r_ivv         <= VVAR_RST;
            r_last        <= '0;
            for (int a = 0; a < NA; a++) begin
                r_pos[a]  <= '0;
                r_vel[a]  <= '0;
                r_pvar[a] <= ONE_FX;
                r_vvar[a] <= VVAR_RST;
            end
        end else begin
            r_div_start <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;

            // take configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dkt_pkg::CFG_PROC_NOISE: r_pn  <= i_cfg_data;
                    dkt_pkg::CFG_MEAS_NOISE: r_mn  <= i_cfg_data;
                    dkt_pkg::CFG_INIT_PVAR:  r_ipv <= i_cfg_data;
                    dkt_pkg::CFG_INIT_VVAR:  r_ivv <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_skip <= 1'b0;
                        case (i_func)
                            dkt_pkg::FN_INIT: begin
                                for (int a = 0; a < NA; a++) begin
                                    if (a < AXES) begin
                                        r_pos[a]  <= in_coord[a];
                                        r_vel[a]  <= '0;
                                        r_pvar[a] <= r_ipv;
                                        r_vvar[a] <= r_ivv;
                                    end
                                end
                                r_last  <= i_time_stamp;
                                r_state <= ST_DONE;
                            end
                            dkt_pkg::FN_PREDICT: begin
                                if (n_dt[DW-1] || n_dt == '0) begin
                                    r_skip  <= 1'b1;
                                    r_state <= ST_DONE;
                                end else begin
                                    r_dt    <= n_dt;
                                    r_ts    <= i_time_stamp;
                                    r_op    <= OP_GROW;
                                    r_state <= ST_MUL;
                                end
                            end
                            dkt_pkg::FN_UPDATE: begin
                                for (int a = 0; a < NA; a++) r_coord[a] <= in_coord[a];
                                r_axis  <= '0;
                                r_state <= ST_AXIS;
                            end
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_MUL: r_state <= ST_APPLY;
                ST_APPLY: begin
                    r_state <= ST_MUL;
                    case (r_op)
                        OP_GROW: begin
                            r_grow <= corr;
                            r_axis <= '0;
                            r_op   <= OP_PPOS;
                        end
                        OP_PPOS: begin
                            r_pos[r_axis]  <= add_scaled(r_pos[r_axis], corr,
                                                         r_vel[r_axis][DW-1]);
                            r_pvar[r_axis] <= add_sat(r_pvar[r_axis], r_grow);
                            r_vvar[r_axis] <= add_sat(r_vvar[r_axis], r_grow);
                            if (last_axis) begin
                                r_last  <= r_ts;
                                r_state <= ST_DONE;
                            end else begin
                                r_axis <= r_axis + 1'b1;
                            end
                        end
                        OP_KPOS: begin
                            r_pos[r_axis] <= add_scaled(r_pos[r_axis], corr, r_ineg);
                            r_op          <= OP_KVVEL;
                        end
                        OP_KVVEL: begin
                            r_vel[r_axis] <= add_scaled(r_vel[r_axis], corr, r_ineg);
                            r_op          <= OP_PPVAR;
                        end
                        OP_PPVAR: begin
                            r_pvar[r_axis] <= corr[DW-1:0];
                            r_op           <= OP_PVVAR;
                        end
                        OP_PVVAR: begin
                            r_vvar[r_axis] <= corr[DW-1:0];
                            if (last_axis) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_axis  <= r_axis + 1'b1;
                                r_state <= ST_AXIS;
                            end
                        end
                        default: r_state <= ST_DONE;
                    endcase
                end
                ST_AXIS: begin
                    // latch innovation and launch the position gain division
                    r_ineg      <= n_innov[DW];
                    r_imag      <= n_innov[DW] ? DW'(-n_innov) : n_innov[DW-1:0];
                    r_szero     <= (div_dsr == '0);
                    r_div_kv    <= 1'b0;
                    r_div_start <= 1'b1;
                    r_state     <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (!r_div_kv) begin
                            r_k         <= r_szero ? '0 : div_q[DW-1:0];
                            r_div_kv    <= 1'b1;
                            r_div_start <= 1'b1;
                        end else begin
                            if (r_szero)               r_kv <= '0;
                            else if (|div_q[DVD_W-1:DW]) r_kv <= '1;
                            else                       r_kv <= div_q[DW-1:0];
                            r_op    <= OP_KPOS;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_DONE: begin
                    // hand the result to the output register once it is free
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // load the result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_ovalid || !i_stall)) begin
            for (int a = 0; a < NA; a++) begin
                r_opos[a] <= r_pos[a];
                r_ovel[a] <= r_vel[a];
            end
            r_oskip <= r_skip;
        end
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_ovalid;
    assign o_pos_x        = r_opos[0];
    assign o_pos_y        = r_opos[1];
    assign o_pos_z        = r_opos[2];
    assign o_vel_x        = r_ovel[0];
    assign o_vel_y        = r_ovel[1];
    assign o_vel_z        = r_ovel[2];
    assign o_step_skipped = r_oskip;

endmodule

// File: rtl/dkt_chk.sv
`timescale 1ns / 1ps

module dkt_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_pos_x,
    input logic               o_step_skipped
);

    // an accepted item leaves the block busy in the cycle after
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after an item");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_pos_x) && $stable(o_step_skipped)))
        else $error("result payload changed while stalled");

endmodule

bind diagonal_kalman_tracker_3d_core dkt_chk u_dkt_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_pos_x        (o_pos_x),
    .o_step_skipped (o_step_skipped)
);
